### src/mrls_pkg.sv
// Shared types, constants and helpers for the maximal repeat LCP stack.
// No dependencies; used by mrls_front, mrls_back and maximal_repeat_lcp_stack.
package mrls_pkg;

  // stack geometry
  localparam int StackDepth = 64;
  localparam int CntW       = 7;   // holds 0 .. StackDepth
  localparam int IdxW       = 6;   // addresses 0 .. StackDepth-1

  // field widths
  localparam int CharW = 7;
  localparam int LenW  = 16;
  localparam int PosW  = 32;
  localparam int HalfW = 64;
  localparam int SetW  = 2 * HalfW;

  // stream packing
  localparam int InDataW  = 56;
  localparam int OutDataW = 48;

  // threshold after reset and in place of a zero write
  localparam logic [LenW-1:0] MinLenRepeat1 = 16'd1;

  // item as it travels through the queue
  typedef struct packed {
    logic             flush;
    logic             len_ok;
    logic [CharW-1:0] chr;
    logic [LenW-1:0]  len;
    logic [PosW-1:0]  pos;
  } item_t;

  // one open interval
  typedef struct packed {
    logic [SetW-1:0] chars;
    logic [LenW-1:0] len;
    logic [PosW-1:0] pos;
  } entry_t;

  // status from the back end
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            overflow;
  } status_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackEval,
    BackLoad
  } back_state_e;

  // one-hot set bit for a character
  function automatic logic [SetW-1:0] char_onehot(input logic [CharW-1:0] c);
    logic [SetW-1:0] v;
    v = {{(SetW-1){1'b0}}, 1'b1} << c;
    return v;
  endfunction

  // true when the set holds at least two characters
  function automatic logic two_distinct(input logic [SetW-1:0] s);
    logic [HalfW-1:0] lo;
    logic [HalfW-1:0] hi;
    lo = s[HalfW-1:0];
    hi = s[SetW-1:HalfW];
    return ((lo & (lo - HalfW'(1))) != '0) || ((hi & (hi - HalfW'(1))) != '0) ||
           ((lo != '0) && (hi != '0));
  endfunction

endpackage

### src/mrls_front.sv
// Front end: takes input beats, classifies them and holds them in a two-entry queue.
// Depends on mrls_pkg.
module mrls_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mrls_pkg::LenW-1:0]       min_len_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_flush_i,
  input  logic [mrls_pkg::CharW-1:0]      in_char_i,
  input  logic [mrls_pkg::LenW-1:0]       in_len_i,
  input  logic [mrls_pkg::PosW-1:0]       in_pos_i,
  output logic                            q_valid_o,
  input  logic                            q_ready_i,
  output mrls_pkg::item_t                 q_item_o
);

  mrls_pkg::item_t slot_q [2];
  mrls_pkg::item_t new_item;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;
  logic            push, pop;
  logic [mrls_pkg::LenW-1:0] min_eff;

  // a zero threshold acts as one
  assign min_eff = (min_len_i == '0) ? mrls_pkg::MinLenRepeat1 : min_len_i;

  // classify the beat
  always_comb begin
    new_item.flush  = in_flush_i;
    new_item.len_ok = in_len_i >= min_eff;
    new_item.chr    = in_char_i;
    new_item.len    = in_len_i;
    new_item.pos    = in_pos_i;
  end

  assign in_ready_o = fill_q != 2'd2;
  assign q_valid_o  = fill_q != 2'd0;
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= new_item;
  end

endmodule

### src/mrls_back.sv
// Back end: interval stack with the top entry in registers and the rest in a memory,
// report holding stage and output register. Depends on mrls_pkg.
module mrls_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  mrls_pkg::item_t                   q_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mrls_pkg::PosW-1:0]         out_pos_o,
  output logic [mrls_pkg::LenW-1:0]         out_len_o,
  output logic                              out_last_o,
  output logic                              out_ovf_o,
  output mrls_pkg::status_t                 status_o
);

  mrls_pkg::back_state_e state_q, state_d;
  mrls_pkg::item_t       cur_q, cur_d;
  mrls_pkg::entry_t      top_q, top_d;
  mrls_pkg::entry_t      rd_data_q;
  mrls_pkg::entry_t      mem [mrls_pkg::StackDepth];
  logic [mrls_pkg::CntW-1:0] count_q, count_d;
  logic [mrls_pkg::SetW-1:0] carry_q, carry_d;
  logic [mrls_pkg::SetW-1:0] merged;
  logic [mrls_pkg::CharW-1:0] row_char_q, row_char_d;
  logic row_valid_q, row_valid_d;
  logic ovf_q, ovf_d;
  logic pend_valid_q, pend_valid_d;
  logic [mrls_pkg::PosW-1:0] pend_pos_q, pend_pos_d;
  logic [mrls_pkg::LenW-1:0] pend_len_q, pend_len_d;
  logic out_valid_q, out_valid_d;
  logic [mrls_pkg::PosW-1:0] out_pos_q, out_pos_d;
  logic [mrls_pkg::LenW-1:0] out_len_q, out_len_d;
  logic out_last_q, out_last_d;
  logic out_ovf_q, out_ovf_d;
  logic out_free, pop_now, report;
  logic wr_en, rd_en;
  logic [mrls_pkg::CntW-1:0] top_idx, below_idx;

  assign out_free  = !out_valid_q || out_ready_i;
  assign merged    = top_q.chars | carry_q;
  assign report    = mrls_pkg::two_distinct(merged);
  assign pop_now   = (count_q != '0) && (cur_q.flush || (cur_q.len < top_q.len));
  assign top_idx   = count_q - mrls_pkg::CntW'(1);
  assign below_idx = count_q - mrls_pkg::CntW'(2);
  assign q_ready_o = state_q == mrls_pkg::BackIdle;

  // sequencer: pop, refill the top from memory, then merge or push
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    top_d        = top_q;
    count_d      = count_q;
    carry_d      = carry_q;
    row_char_d   = row_char_q;
    row_valid_d  = row_valid_q;
    ovf_d        = ovf_q;
    pend_valid_d = pend_valid_q;
    pend_pos_d   = pend_pos_q;
    pend_len_d   = pend_len_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_pos_d    = out_pos_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    unique case (state_q)
      mrls_pkg::BackIdle: begin
        if (q_valid_i) begin
          cur_d   = q_item_i;
          carry_d = '0;
          state_d = mrls_pkg::BackEval;
        end
      end
      mrls_pkg::BackEval: begin
        if (pop_now) begin
          // close the top interval, hand its set to the parent
          if (!(report && pend_valid_q) || out_free) begin
            carry_d = merged;
            count_d = top_idx;
            if (report) begin
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_pos_d   = pend_pos_q;
                out_len_d   = pend_len_q;
                out_last_d  = 1'b0;
                out_ovf_d   = ovf_q;
              end
              pend_valid_d = 1'b1;
              pend_pos_d   = top_q.pos;
              pend_len_d   = top_q.len;
            end
            if (count_q >= mrls_pkg::CntW'(2)) begin
              rd_en   = 1'b1;
              state_d = mrls_pkg::BackLoad;
            end
          end
        end else if (!pend_valid_q || out_free) begin
          // end of the item: merge or push, release the held report
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_pos_d    = pend_pos_q;
            out_len_d    = pend_len_q;
            out_last_d   = 1'b1;
            out_ovf_d    = ovf_q;
            pend_valid_d = 1'b0;
          end
          if (cur_q.flush) begin
            row_valid_d = 1'b0;
          end else begin
            if ((count_q != '0) && (cur_q.len == top_q.len)) begin
              top_d.chars = top_q.chars | carry_q | mrls_pkg::char_onehot(cur_q.chr);
            end else if (cur_q.len_ok) begin
              if (count_q == mrls_pkg::CntW'(mrls_pkg::StackDepth)) begin
                ovf_d = 1'b1;
              end else begin
                wr_en       = count_q != '0;
                top_d.pos   = cur_q.pos;
                top_d.len   = cur_q.len;
                top_d.chars = carry_q | mrls_pkg::char_onehot(cur_q.chr) |
                              (row_valid_q ? mrls_pkg::char_onehot(row_char_q) : '0);
                count_d     = count_q + mrls_pkg::CntW'(1);
              end
            end
            row_char_d  = cur_q.chr;
            row_valid_d = 1'b1;
          end
          state_d = mrls_pkg::BackIdle;
        end
      end
      mrls_pkg::BackLoad: begin
        top_d   = rd_data_q;
        state_d = mrls_pkg::BackEval;
      end
      default: state_d = mrls_pkg::BackIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mrls_pkg::BackIdle;
      count_q      <= '0;
      row_valid_q  <= 1'b0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      row_valid_q  <= row_valid_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    top_q      <= top_d;
    carry_q    <= carry_d;
    row_char_q <= row_char_d;
    pend_pos_q <= pend_pos_d;
    pend_len_q <= pend_len_d;
    out_pos_q  <= out_pos_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  // stack memory below the top entry, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[top_idx[mrls_pkg::IdxW-1:0]] <= top_q;
    if (rd_en) rd_data_q <= mem[below_idx[mrls_pkg::IdxW-1:0]];
  end

  assign out_valid_o       = out_valid_q;
  assign out_pos_o         = out_pos_q;
  assign out_len_o         = out_len_q;
  assign out_last_o        = out_last_q;
  assign out_ovf_o         = out_ovf_q;
  assign status_o.count    = count_q;
  assign status_o.overflow = ovf_q;

endmodule

### src/maximal_repeat_lcp_stack.sv
// Maximal repeat finder over suffix-array rows. A beat waits in the two-entry queue, then
// is picked up and finished, with a pop and a refill of the top from the stack memory's
// registered read for each interval it closes, but no refill for a pop that empties the
// stack; the next beat is picked up only after this one. A result leaves once its report
// is followed by another or by the end of its item. Reset (asynchronous, active low) clears
// queue, stack count, flags and threshold (to 1); stack memory is read only if written.
module maximal_repeat_lcp_stack (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mrls_pkg::LenW-1:0]            cfg_wdata_i,   // min_repeat_len
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mrls_pkg::InDataW-1:0]         s_axis_tdata,  // prev_char, common_len, text_pos
  input  logic                                 s_axis_tuser,  // flush
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mrls_pkg::OutDataW-1:0]        m_axis_tdata,  // repeat_pos, repeat_len
  output logic                                 m_axis_tlast,  // last
  output logic                                 m_axis_tuser   // overflowed
);

  logic [mrls_pkg::LenW-1:0] min_len_q;
  logic                      q_valid, q_ready;
  mrls_pkg::item_t           q_item;
  mrls_pkg::status_t         status;
  logic [mrls_pkg::PosW-1:0] out_pos;
  logic [mrls_pkg::LenW-1:0] out_len;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= mrls_pkg::MinLenRepeat1;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  mrls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .min_len_i  (min_len_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_flush_i (s_axis_tuser),
    .in_char_i  (s_axis_tdata[6:0]),
    .in_len_i   (s_axis_tdata[22:7]),
    .in_pos_i   (s_axis_tdata[54:23]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  mrls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_len_o   (out_len),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser),
    .status_o    (status)
  );

  assign m_axis_tdata = {out_len, out_pos};

`ifndef SYNTHESIS
  // stack never holds more than its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.count <= mrls_pkg::CntW'(mrls_pkg::StackDepth))
    else $error("stack count beyond depth");

  // stack moves by at most one entry a cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.count != $past(status.count)) |->
      ((status.count == $past(status.count) + mrls_pkg::CntW'(1)) ||
       (status.count == $past(status.count) - mrls_pkg::CntW'(1))))
    else $error("stack count jumped");

  // overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.overflow |=> status.overflow)
    else $error("overflow flag cleared");
`endif

endmodule

### tb/tb_maximal_repeat_lcp_stack.sv
`timescale 1ns / 100ps
// Self-checking bench for maximal_repeat_lcp_stack: streams suffix-array rows and flushes,
// predicts the reported repeats and compares every output beat against the prediction.
// Depends on mrls_pkg and maximal_repeat_lcp_stack.
module tb_maximal_repeat_lcp_stack;

  localparam int IdlePct     = 14;
  localparam int DrainCycles = 400;
  localparam int LongHold    = 400;

  // one reported repeat as it should leave the block
  typedef struct {
    logic [mrls_pkg::PosW-1:0] pos;
    logic [mrls_pkg::LenW-1:0] len;
    bit                        last;
    bit                        ovf;
  } repeat_rec_t;

  // interval stack predictor plus the queue of repeats still owed by the block
  class repeat_scoreboard;
    logic [mrls_pkg::PosW-1:0]  ent_pos [mrls_pkg::StackDepth];
    logic [mrls_pkg::LenW-1:0]  ent_len [mrls_pkg::StackDepth];
    logic [mrls_pkg::SetW-1:0]  ent_set [mrls_pkg::StackDepth];
    int                         open_cnt;
    bit                         overflow_flag;
    logic [mrls_pkg::LenW-1:0]  min_len;
    logic [mrls_pkg::CharW-1:0] prior_char;
    bit                         prior_ok;
    logic [mrls_pkg::SetW-1:0]  carry_set;
    repeat_rec_t                batch[$];
    repeat_rec_t                repeats_due[$];
    int                         errors;
    int                         checked;

    function new();
      open_cnt      = 0;
      overflow_flag = 1'b0;
      min_len       = mrls_pkg::MinLenRepeat1;
      prior_char    = '0;
      prior_ok      = 1'b0;
      errors        = 0;
      checked       = 0;
    endfunction

    function logic [mrls_pkg::SetW-1:0] char_mask(input logic [mrls_pkg::CharW-1:0] c);
      return mrls_pkg::SetW'(1) << c;
    endfunction

    // close the top interval, folding in what the closed children carried up
    function void close_top();
      repeat_rec_t r;
      open_cnt--;
      carry_set |= ent_set[open_cnt];
      if ($countones(carry_set) >= 2) begin
        r.pos  = ent_pos[open_cnt];
        r.len  = ent_len[open_cnt];
        r.last = 1'b0;
        r.ovf  = 1'b0;
        batch.push_back(r);
      end
    endfunction

    // work out the repeats that one accepted input beat causes
    function void note_row(input bit flush, input logic [mrls_pkg::CharW-1:0] chr,
                           input logic [mrls_pkg::LenW-1:0] len,
                           input logic [mrls_pkg::PosW-1:0] pos);
      int                        top;
      logic [mrls_pkg::LenW-1:0] thr;
      thr       = (min_len == '0) ? mrls_pkg::MinLenRepeat1 : min_len;
      carry_set = '0;
      batch.delete();
      if (flush) begin
        while (open_cnt > 0) close_top();
        prior_ok = 1'b0;
      end else begin
        while (open_cnt > 0 && len < ent_len[open_cnt-1]) close_top();
        top = open_cnt - 1;
        if (open_cnt > 0 && len == ent_len[top]) begin
          // widen the open interval of equal length
          ent_set[top] |= carry_set | char_mask(chr);
        end else if (len >= thr) begin
          if (open_cnt >= mrls_pkg::StackDepth) begin
            overflow_flag = 1'b1;
          end else begin
            ent_pos[open_cnt] = pos;
            ent_len[open_cnt] = len;
            ent_set[open_cnt] = carry_set | char_mask(chr) |
                                (prior_ok ? char_mask(prior_char) : mrls_pkg::SetW'(0));
            open_cnt++;
          end
        end
        prior_char = chr;
        prior_ok   = 1'b1;
      end
      foreach (batch[k]) begin
        batch[k].last = (k == batch.size() - 1);
        batch[k].ovf  = overflow_flag;
        repeats_due.push_back(batch[k]);
      end
    endfunction

    // compare one output beat with the oldest owed repeat
    function void check_repeat(input logic [mrls_pkg::PosW-1:0] pos,
                               input logic [mrls_pkg::LenW-1:0] len,
                               input logic last, input logic ovf);
      repeat_rec_t e;
      if (repeats_due.size() == 0) begin
        $error("unexpected repeat: pos %0h len %0d", pos, len);
        errors++;
        return;
      end
      e = repeats_due.pop_front();
      checked++;
      if (pos !== e.pos) begin
        $error("repeat_pos mismatch: expected %0h, actual %0h", e.pos, pos);
        errors++;
      end
      if (len !== e.len) begin
        $error("repeat_len mismatch: expected %0d, actual %0d", e.len, len);
        errors++;
      end
      if (last !== e.last) begin
        $error("last mismatch: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflowed mismatch: expected %0b, actual %0b", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [mrls_pkg::LenW-1:0]     cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mrls_pkg::InDataW-1:0]  s_axis_tdata  = '0;   // prev_char, common_len, text_pos
  logic                          s_axis_tuser  = 1'b0; // flush
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mrls_pkg::OutDataW-1:0] m_axis_tdata;         // repeat_pos, repeat_len
  logic                          m_axis_tlast;         // last
  logic                          m_axis_tuser;         // overflowed

  repeat_scoreboard sb = new();
  int               idle_pct     = IdlePct;
  bit               hold_request = 1'b0;
  int               rows_sent    = 0;
  int               flushes_sent = 0;

  maximal_repeat_lcp_stack u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // offer one beat, with a random gap first, and wait for it to be taken
  task automatic send_row(input bit flush, input logic [mrls_pkg::CharW-1:0] chr,
                          input logic [mrls_pkg::LenW-1:0] len,
                          input logic [mrls_pkg::PosW-1:0] pos);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pos, len, chr};
    s_axis_tuser  <= flush;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_row(flush, chr, len, pos);
    if (flush) flushes_sent++;
    else rows_sent++;
  endtask

  // flush beat, the row fields carry noise
  task automatic send_flush();
    send_row(1'b1, mrls_pkg::CharW'($urandom), mrls_pkg::LenW'($urandom),
             mrls_pkg::PosW'($urandom));
  endtask

  // stop offering, wait for every owed repeat, then let the block settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.repeats_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_min_len(input logic [mrls_pkg::LenW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.min_len   = value;
  endtask

  // runs of rows with lcp values around the threshold, mostly closed by a flush
  task automatic random_rows(input int count);
    int                         left;
    int                         run_len;
    int                         kind;
    int                         v;
    bit                         narrow;
    logic [mrls_pkg::CharW-1:0] base;
    logic [mrls_pkg::CharW-1:0] chr;
    logic [mrls_pkg::LenW-1:0]  len;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(3, 20);
      narrow  = ($urandom_range(0, 2) == 0);
      base    = mrls_pkg::CharW'($urandom_range(0, 127));
      for (int k = 0; k < run_len && left > 0; k++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          len = '0;
        end else if (kind == 1) begin
          len = mrls_pkg::LenW'($urandom);
        end else begin
          v   = int'(sb.min_len) + int'($urandom_range(0, 6)) - 1;
          len = (v < 0) ? '0 : (v > 65535) ? '1 : mrls_pkg::LenW'(v);
        end
        // narrow runs use two neighbouring characters, so some sets stay single
        chr = narrow ? base + mrls_pkg::CharW'($urandom_range(0, 1)) :
                       mrls_pkg::CharW'($urandom_range(0, 127));
        send_row(1'b0, chr, len, mrls_pkg::PosW'($urandom));
        left--;
      end
      if (left > 0 && $urandom_range(0, 9) < 8) begin
        send_flush();
        left--;
      end
    end
  endtask

  // output side: check taken beats, random stalls and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_repeat(m_axis_tdata[mrls_pkg::PosW-1:0],
                        m_axis_tdata[mrls_pkg::PosW+mrls_pkg::LenW-1:mrls_pkg::PosW],
                        m_axis_tlast, m_axis_tuser);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LongHold;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_min_len(mrls_pkg::MinLenRepeat1);

    // short row on an empty stack only leaves its character behind
    send_row(1'b0, 7'd0, 16'd0, 32'd0);
    // longest lcp, top character, widest position, then widened
    send_row(1'b0, 7'd127, 16'hFFFF, 32'hFFFF_FFFF);
    send_row(1'b0, 7'd127, 16'hFFFF, 32'd1);
    // closes the long interval, new one inherits its characters
    send_row(1'b0, 7'd5, 16'd3, 32'd2);
    send_row(1'b0, 7'd5, 16'd3, 32'd3);
    send_row(1'b0, 7'd64, 16'd2, 32'h8000_0000);
    send_flush();
    // single character interval, never reported
    send_row(1'b0, 7'd9, 16'd0, 32'd10);
    send_row(1'b0, 7'd9, 16'd4, 32'd11);
    send_row(1'b0, 7'd9, 16'd4, 32'd12);
    send_flush();
    // flush with nothing open
    send_flush();
    // characters on either side of the low and high half of the set
    send_row(1'b0, 7'd63, 16'd0, 32'd20);
    send_row(1'b0, 7'd64, 16'd7, 32'd21);
    send_row(1'b0, 7'd64, 16'd9, 32'd22);
    // zero lcp closes everything without opening
    send_row(1'b0, 7'd1, 16'd0, 32'd23);
    send_flush();
    wait_drained();

    // zero threshold behaves as one
    write_min_len('0);
    random_rows(100);
    wait_drained();

    // highest threshold, no idling on either side
    idle_pct = 0;
    write_min_len('1);
    random_rows(40);
    wait_drained();

    // output held off for a long stretch while rows keep coming
    idle_pct = IdlePct;
    write_min_len(16'd3);
    hold_request = 1'b1;
    random_rows(100);
    wait_drained();

    // climbing lcp past the stack depth, then one flush closes every entry
    idle_pct = 0;
    write_min_len(16'd1);
    for (int k = 1; k <= mrls_pkg::StackDepth + 6; k++)
      send_row(1'b0, mrls_pkg::CharW'($urandom_range(0, 127)), mrls_pkg::LenW'(k),
               mrls_pkg::PosW'($urandom));
    send_flush();
    idle_pct = IdlePct;
    random_rows(100);
    wait_drained();

    write_min_len(mrls_pkg::LenW'($urandom_range(1, 12)));
    random_rows(40);
    wait_drained();

    if (sb.repeats_due.size() != 0) begin
      $error("%0d repeats never arrived", sb.repeats_due.size());
      sb.errors += sb.repeats_due.size();
    end
    $display("covered %0d rows and %0d flushes over six threshold settings",
             rows_sent, flushes_sent);
    $display("%0d repeats checked, stack overflow %s", sb.checked,
             sb.overflow_flag ? "reached" : "not reached");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
